>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clock; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CFA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define CFA_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) else $error("assertion failed");
`else
`define CFA_ASSERT(label, prop)
`define CFA_ASSERT_ALWAYS(label, prop)
`endif
`endif

>>> design/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and codes of the contiguous fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package cfa_pkg;
   localparam int LEN_W = 21;
   localparam int PID_W = 8;
   localparam int ACT_W = 2;
   localparam int FIT_W = 2;
   localparam int ST_W  = 2;
   localparam int TSZ_W = 21;

   localparam logic [TSZ_W-1:0] TOTAL_RESET = 21'd1048576;

   typedef logic [ST_W-1:0] status_type;
   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_TABLE_FULL = 2'd1;
   localparam status_type ST_NO_SPACE   = 2'd2;
   localparam status_type ST_NOT_FOUND  = 2'd3;

   localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_COMPACT = 2'd2;

   localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_START,
      DP_SCAN_RD,
      DP_SCAN_EV,
      DP_TAIL_EV,
      DP_INS_INIT,
      DP_INS_RD,
      DP_INS_WR,
      DP_PLACE,
      DP_REL_RD,
      DP_REL_EV,
      DP_SHF_RD,
      DP_SHF_WR,
      DP_REL_DONE,
      DP_CMP_RD,
      DP_CMP_WR,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             table_full;
      logic             no_work;
      logic             rule_first;
      logic             at_end;
      logic             take;
      logic             found;
      logic             at_slot;
      logic             match;
      logic             shift_end;
   } dp_sts_type;
endpackage
`default_nettype wire

>>> design/cfa_datapath.sv
// ----------------------------------------------------------------------------
// cfa_datapath
// Region table memories, hole search, table shifting and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cfa_datapath
   import cfa_pkg::*;
#(
   parameter int MAX_REGIONS = 64,
   parameter int ADDR_BITS   = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire dp_cmd_type                         cmd,
   output dp_sts_type                              sts,
   input  wire logic [ACT_W-1:0]                   req_action,
   input  wire logic [PID_W-1:0]                   req_process_id,
   input  wire logic [LEN_W-1:0]                   req_request_size,
   input  wire logic [FIT_W-1:0]                   req_fit_strategy,
   input  wire logic                               csr_write_enable,
   input  wire logic [TSZ_W-1:0]                   csr_write_data,
   output logic                                    rsp_valid,
   output logic [ST_W-1:0]                         rsp_status,
   output logic [ADDR_BITS-1:0]                    rsp_start_address,
   output logic [$clog2(MAX_REGIONS+1)-1:0]        rsp_regions_in_use
);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int IW = $clog2(MAX_REGIONS);
   localparam int SW = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;

   logic [ADDR_BITS-1:0] start_mem_ff [MAX_REGIONS];
   logic [LEN_W-1:0]     len_mem_ff   [MAX_REGIONS];
   logic [PID_W-1:0]     owner_mem_ff [MAX_REGIONS];
   logic [ADDR_BITS-1:0] rd_start_ff;
   logic [LEN_W-1:0]     rd_len_ff;
   logic [PID_W-1:0]     rd_owner_ff;

   logic [ACT_W-1:0]     action_ff, action_in;
   logic [PID_W-1:0]     owner_ff, owner_in;
   logic [LEN_W-1:0]     want_ff, want_in;
   logic [FIT_W-1:0]     rule_ff, rule_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [SW-1:0]        cursor_ff, cursor_in;
   logic                 found_ff, found_in;
   logic [SW-1:0]        chosen_size_ff, chosen_size_in;
   logic [ADDR_BITS-1:0] best_addr_ff, best_addr_in;
   logic [CW-1:0]        best_slot_ff, best_slot_in;
   logic [TSZ_W-1:0]     total_ff, total_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic [CW-1:0]        rsp_count_ff, rsp_count_in;

   logic [CW-1:0]        idx_inc;
   logic [CW-1:0]        idx_dec;
   logic [IW-1:0]        rd_addr;
   logic [IW-1:0]        wr_addr;
   logic                 we_start;
   logic                 we_rest;
   logic [ADDR_BITS-1:0] wd_start;
   logic [LEN_W-1:0]     wd_len;
   logic [PID_W-1:0]     wd_owner;
   logic [SW-1:0]        cap;
   logic [SW-1:0]        tot;
   logic [SW-1:0]        limit;
   logic [SW-1:0]        gap_end;
   logic [SW-1:0]        hole;
   logic [SW-1:0]        stop;
   logic                 fits;
   logic                 take;

   assign idx_inc = idx_ff + CW'(1);
   assign idx_dec = idx_ff - CW'(1);
   assign wr_addr = idx_ff[IW-1:0];

   always_comb begin
      case (cmd.op)
         DP_INS_RD: rd_addr = idx_dec[IW-1:0];
         DP_SHF_RD: rd_addr = idx_inc[IW-1:0];
         default:   rd_addr = idx_ff[IW-1:0];
      endcase
   end

   always_comb begin
      we_start = 1'b0;
      we_rest  = 1'b0;
      wd_start = rd_start_ff;
      wd_len   = rd_len_ff;
      wd_owner = rd_owner_ff;
      case (cmd.op)
         DP_INS_WR, DP_SHF_WR: begin
            we_start = 1'b1;
            we_rest  = 1'b1;
         end
         DP_PLACE: begin
            we_start = 1'b1;
            we_rest  = 1'b1;
            wd_start = best_addr_ff;
            wd_len   = want_ff;
            wd_owner = owner_ff;
         end
         DP_CMP_WR: begin
            we_start = 1'b1;
            wd_start = cursor_ff[ADDR_BITS-1:0];
         end
         default: begin
            we_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_start) begin
         start_mem_ff[wr_addr] <= wd_start;
      end
      if (we_rest) begin
         len_mem_ff[wr_addr]   <= wd_len;
         owner_mem_ff[wr_addr] <= wd_owner;
      end
      rd_start_ff <= start_mem_ff[rd_addr];
      rd_len_ff   <= len_mem_ff[rd_addr];
      rd_owner_ff <= owner_mem_ff[rd_addr];
   end

   assign cap     = SW'(1) << ADDR_BITS;
   assign tot     = SW'(total_ff);
   assign limit   = (tot > cap) ? cap : tot;
   assign gap_end = (cmd.op == DP_TAIL_EV) ? limit : SW'(rd_start_ff);
   assign hole    = (gap_end > cursor_ff) ? (gap_end - cursor_ff) : '0;
   assign stop    = SW'(rd_start_ff) + SW'(rd_len_ff);
   assign fits    = hole >= SW'(want_ff);

   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (rule_ff == FIT_FIRST) begin
            take = 1'b1;
         end else if (rule_ff == FIT_BEST) begin
            take = !found_ff || (hole < chosen_size_ff);
         end else if (rule_ff == FIT_WORST) begin
            take = !found_ff || (hole > chosen_size_ff);
         end
      end
   end

   always_comb begin
      action_in      = action_ff;
      owner_in       = owner_ff;
      want_in        = want_ff;
      rule_in        = rule_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      cursor_in      = cursor_ff;
      found_in       = found_ff;
      chosen_size_in = chosen_size_ff;
      best_addr_in   = best_addr_ff;
      best_slot_in   = best_slot_ff;
      total_in       = csr_write_enable ? csr_write_data : total_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_count_in   = rsp_count_ff;
      case (cmd.op)
         DP_START: begin
            action_in      = req_action;
            owner_in       = req_process_id;
            want_in        = req_request_size;
            rule_in        = req_fit_strategy;
            idx_in         = '0;
            cursor_in      = '0;
            found_in       = 1'b0;
            chosen_size_in = '0;
            best_addr_in   = '0;
            best_slot_in   = '0;
         end
         DP_SCAN_EV, DP_TAIL_EV: begin
            if (take) begin
               found_in       = 1'b1;
               chosen_size_in = hole;
               best_addr_in   = cursor_ff[ADDR_BITS-1:0];
               best_slot_in   = idx_ff;
            end
            if (cmd.op == DP_SCAN_EV) begin
               if (stop > cursor_ff) begin
                  cursor_in = stop;
               end
               idx_in = idx_inc;
            end
         end
         DP_INS_INIT: idx_in = count_ff;
         DP_INS_WR:   idx_in = idx_dec;
         DP_PLACE:    count_in = count_ff + CW'(1);
         DP_REL_EV: begin
            if (rd_owner_ff != owner_ff) begin
               idx_in = idx_inc;
            end
         end
         DP_SHF_WR:   idx_in = idx_inc;
         DP_REL_DONE: count_in = count_ff - CW'(1);
         DP_CMP_WR: begin
            cursor_in = cursor_ff + SW'(rd_len_ff);
            idx_in    = idx_inc;
         end
         DP_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.status;
            rsp_addr_in   = ((action_ff == ACT_REQUEST) && (cmd.status == ST_OK)) ?
                            best_addr_ff : '0;
            rsp_count_in  = count_ff;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff      <= action_in;
      owner_ff       <= owner_in;
      want_ff        <= want_in;
      rule_ff        <= rule_in;
      idx_ff         <= idx_in;
      cursor_ff      <= cursor_in;
      found_ff       <= found_in;
      chosen_size_ff <= chosen_size_in;
      best_addr_ff   <= best_addr_in;
      best_slot_ff   <= best_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_comb begin
      sts.action     = action_ff;
      sts.table_full = count_ff >= CW'(MAX_REGIONS);
      sts.no_work    = (want_ff == '0) ||
                       ((rule_ff != FIT_FIRST) && (rule_ff != FIT_BEST) &&
                        (rule_ff != FIT_WORST));
      sts.rule_first = rule_ff == FIT_FIRST;
      sts.at_end     = idx_ff == count_ff;
      sts.take       = take;
      sts.found      = found_ff;
      sts.at_slot    = idx_ff == best_slot_ff;
      sts.match      = rd_owner_ff == owner_ff;
      sts.shift_end  = idx_inc >= count_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_start_address  = rsp_addr_ff;
   assign rsp_regions_in_use = rsp_count_ff;

   `CFA_ASSERT(a_count_max, count_ff <= CW'(MAX_REGIONS))
   `CFA_ASSERT(a_rsp_from_finish, rsp_valid_ff |-> $past(cmd.op == DP_FINISH))
   `CFA_ASSERT(a_count_only_on_update, (cmd.op != DP_PLACE && cmd.op != DP_REL_DONE) |=> $stable(count_ff))
endmodule
`default_nettype wire

>>> design/cfa_control.sv
// ----------------------------------------------------------------------------
// cfa_control
// Sequencer that steps the datapath through search, shift and compaction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module cfa_control
   import cfa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);
   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SCAN_EV,
      S_INS_INIT,
      S_INS,
      S_INS_WR,
      S_REL,
      S_REL_EV,
      S_SHF,
      S_SHF_WR,
      S_CMP,
      S_CMP_WR,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       busy_ff;

   always_comb begin
      state_in   = state_ff;
      status_in  = status_ff;
      cmd.op     = DP_NOP;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = DP_START;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = ST_OK;
            state_in  = S_FINISH;
            if (sts.action == ACT_REQUEST) begin
               if (sts.table_full) begin
                  status_in = ST_TABLE_FULL;
               end else if (sts.no_work) begin
                  status_in = ST_NO_SPACE;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (sts.action == ACT_RELEASE) begin
               state_in = S_REL;
            end else if (sts.action == ACT_COMPACT) begin
               state_in = S_CMP;
            end
         end
         S_SCAN: begin
            if (sts.at_end) begin
               cmd.op = DP_TAIL_EV;
               if (sts.take || sts.found) begin
                  state_in = S_INS_INIT;
               end else begin
                  status_in = ST_NO_SPACE;
                  state_in  = S_FINISH;
               end
            end else begin
               cmd.op   = DP_SCAN_RD;
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cmd.op   = DP_SCAN_EV;
            state_in = (sts.take && sts.rule_first) ? S_INS_INIT : S_SCAN;
         end
         S_INS_INIT: begin
            cmd.op   = DP_INS_INIT;
            state_in = S_INS;
         end
         S_INS: begin
            if (sts.at_slot) begin
               cmd.op    = DP_PLACE;
               status_in = ST_OK;
               state_in  = S_FINISH;
            end else begin
               cmd.op   = DP_INS_RD;
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.op   = DP_INS_WR;
            state_in = S_INS;
         end
         S_REL: begin
            if (sts.at_end) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_FINISH;
            end else begin
               cmd.op   = DP_REL_RD;
               state_in = S_REL_EV;
            end
         end
         S_REL_EV: begin
            cmd.op   = DP_REL_EV;
            state_in = sts.match ? S_SHF : S_REL;
         end
         S_SHF: begin
            if (sts.shift_end) begin
               cmd.op    = DP_REL_DONE;
               status_in = ST_OK;
               state_in  = S_FINISH;
            end else begin
               cmd.op   = DP_SHF_RD;
               state_in = S_SHF_WR;
            end
         end
         S_SHF_WR: begin
            cmd.op   = DP_SHF_WR;
            state_in = S_SHF;
         end
         S_CMP: begin
            if (sts.at_end) begin
               status_in = ST_OK;
               state_in  = S_FINISH;
            end else begin
               cmd.op   = DP_CMP_RD;
               state_in = S_CMP_WR;
            end
         end
         S_CMP_WR: begin
            cmd.op   = DP_CMP_WR;
            state_in = S_CMP;
         end
         S_FINISH: begin
            cmd.op   = DP_FINISH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
         busy_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         busy_ff   <= state_in != S_IDLE;
      end
   end

   assign busy = busy_ff;

   `CFA_ASSERT(a_start_sets_busy, (start && !busy_ff) |=> busy_ff)
   `CFA_ASSERT(a_finish_to_idle, (state_ff == S_FINISH) |=> (state_ff == S_IDLE))
   `CFA_ASSERT_ALWAYS(a_busy_after_reset, reset |=> !busy_ff)
endmodule
`default_nettype wire

>>> design/contiguous_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Region allocator over one linear address space with first, best and
// worst fit placement, release by owner id and compaction.
//
//   Channel   Ports                        Transfer when
//   request   start, busy, req_*           start high and busy low
//   result    rsp_valid, rsp_*             rsp_valid high, one cycle
//   config    csr_write_enable, csr_*      csr_write_enable high
//
// A request scans the region table and then shifts the entries from the
// chosen slot on; a release scans for the owner and shifts the entries
// after it; a compaction walks every entry. The region table has a single
// read port, so each entry passes through a read state and then an
// evaluate or write state. Reset is synchronous and needs no clearing pass.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none
module contiguous_fit_allocator
   import cfa_pkg::*;
#(
   parameter int MAX_REGIONS = 64,
   parameter int ADDR_BITS   = 20
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [ACT_W-1:0]                   req_action,
   input  wire logic [PID_W-1:0]                   req_process_id,
   input  wire logic [LEN_W-1:0]                   req_request_size,
   input  wire logic [FIT_W-1:0]                   req_fit_strategy,
   output logic                                    rsp_valid,
   output logic [ST_W-1:0]                         rsp_status,
   output logic [ADDR_BITS-1:0]                    rsp_start_address,
   output logic [$clog2(MAX_REGIONS+1)-1:0]        rsp_regions_in_use,
   input  wire logic                               csr_write_enable,
   input  wire logic [TSZ_W-1:0]                   csr_write_data
);
   dp_cmd_type cmd;
   dp_sts_type sts;

   cfa_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   cfa_datapath #(
      .MAX_REGIONS (MAX_REGIONS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_process_id     (req_process_id),
      .req_request_size   (req_request_size),
      .req_fit_strategy   (req_fit_strategy),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_start_address  (rsp_start_address),
      .rsp_regions_in_use (rsp_regions_in_use)
   );
endmodule
`default_nettype wire

>>> dv/tb_contiguous_fit_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contiguous_fit_allocator
// Drives requests, releases and compactions into the region allocator
// under several address space sizes and checks every result against a
// region table kept in the testbench that follows each transfer.
// ----------------------------------------------------------------------------
module tb_contiguous_fit_allocator;
   import cfa_pkg::*;

   localparam int NREG = 64;
   localparam int CYCLE_LIMIT = 800000;
   localparam int ACT_NONE = 3;
   localparam int FIT_NONE = 3;

   typedef struct {
      status_type       status;
      logic [19:0]      addr;
      logic [6:0]       count;
   } outcome_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [ACT_W-1:0]    req_action = '0;
   logic [PID_W-1:0]    req_process_id = '0;
   logic [LEN_W-1:0]    req_request_size = '0;
   logic [FIT_W-1:0]    req_fit_strategy = '0;
   logic                rsp_valid;
   logic [ST_W-1:0]     rsp_status;
   logic [19:0]         rsp_start_address;
   logic [6:0]          rsp_regions_in_use;
   logic                csr_write_enable = 1'b0;
   logic [TSZ_W-1:0]    csr_write_data = '0;

   longint unsigned     tbl_start [NREG];
   longint unsigned     tbl_len [NREG];
   longint unsigned     tbl_owner [NREG];
   int                  tbl_count;
   longint unsigned     space_total;
   outcome_t            pending_results[$];
   int                  errors = 0;
   int                  cycles = 0;
   bit                  gaps_on = 1'b1;

   contiguous_fit_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_process_id(req_process_id),
      .req_request_size(req_request_size), .req_fit_strategy(req_fit_strategy),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_start_address(rsp_start_address), .rsp_regions_in_use(rsp_regions_in_use),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic outcome_t allocate_predict(int act, int pid, longint unsigned want,
                                                 int fit);
      outcome_t r;
      longint unsigned lim, cursor, hole, chosen_size, stop, e, addr;
      int slot, j;
      bit found;
      r.status = ST_OK;
      r.addr = '0;
      if (act == ACT_REQUEST) begin
         lim = (space_total > (64'd1 << 20)) ? (64'd1 << 20) : space_total;
         cursor = 0;
         found = 0;
         chosen_size = 0;
         addr = 0;
         slot = 0;
         if (tbl_count >= NREG) r.status = ST_TABLE_FULL;
         else begin
            for (int i = 0; i <= tbl_count; i++) begin
               e = (i == tbl_count) ? lim : tbl_start[i];
               hole = (e > cursor) ? e - cursor : 0;
               if (want != 0 && hole >= want && !(fit == FIT_FIRST && found)) begin
                  if (fit == FIT_FIRST ||
                      (fit == FIT_BEST && (!found || hole < chosen_size)) ||
                      (fit == FIT_WORST && (!found || hole > chosen_size))) begin
                     found = 1;
                     chosen_size = hole;
                     addr = cursor;
                     slot = i;
                  end
               end
               if (i < tbl_count) begin
                  stop = tbl_start[i] + tbl_len[i];
                  if (stop > cursor) cursor = stop;
               end
            end
            if (!found) r.status = ST_NO_SPACE;
            else begin
               for (j = tbl_count; j > slot; j--) begin
                  tbl_start[j] = tbl_start[j-1];
                  tbl_len[j] = tbl_len[j-1];
                  tbl_owner[j] = tbl_owner[j-1];
               end
               tbl_start[slot] = addr;
               tbl_len[slot] = want;
               tbl_owner[slot] = pid;
               tbl_count++;
               r.addr = addr[19:0];
            end
         end
      end else if (act == ACT_RELEASE) begin
         r.status = ST_NOT_FOUND;
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_owner[i] == pid) begin
               for (j = i; j + 1 < tbl_count; j++) begin
                  tbl_start[j] = tbl_start[j+1];
                  tbl_len[j] = tbl_len[j+1];
                  tbl_owner[j] = tbl_owner[j+1];
               end
               tbl_count--;
               r.status = ST_OK;
               break;
            end
         end
      end else if (act == ACT_COMPACT) begin
         cursor = 0;
         for (int i = 0; i < tbl_count; i++) begin
            tbl_start[i] = cursor;
            cursor += tbl_len[i];
         end
      end
      r.count = tbl_count[6:0];
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with no transfer waiting");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_start_address !== want.addr) begin
               $error("start_address expected %0d actual %0d", want.addr, rsp_start_address);
               errors++;
            end
            if (rsp_regions_in_use !== want.count) begin
               $error("regions_in_use expected %0d actual %0d", want.count,
                      rsp_regions_in_use);
               errors++;
            end
         end
      end
   end

   task automatic send_item(int act, int pid, longint unsigned size, int fit);
      if (gaps_on) begin
         while ($urandom_range(99) < 15) @(negedge clock);
      end
      @(negedge clock);
      req_action <= ACT_W'(act);
      req_process_id <= PID_W'(pid);
      req_request_size <= size[20:0];
      req_fit_strategy <= FIT_W'(fit);
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(allocate_predict(act, pid, size & 64'h1FFFFF, fit));
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_total_size(longint unsigned v);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v[20:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      space_total = v & 64'h1FFFFF;
   endtask

   task automatic test_directed();
      send_item(ACT_REQUEST, 7, 1048576, FIT_FIRST);
      send_item(ACT_REQUEST, 8, 1, FIT_BEST);
      send_item(ACT_RELEASE, 7, 0, FIT_FIRST);
      send_item(ACT_RELEASE, 7, 2097151, FIT_NONE);
      send_item(ACT_REQUEST, 9, 0, FIT_FIRST);
      send_item(ACT_REQUEST, 9, 5, FIT_NONE);
      send_item(ACT_NONE, 255, 2097151, FIT_NONE);
      send_item(ACT_COMPACT, 0, 0, FIT_FIRST);
      send_item(ACT_REQUEST, 1, 100, FIT_FIRST);
      send_item(ACT_REQUEST, 2, 50, FIT_FIRST);
      send_item(ACT_REQUEST, 3, 200, FIT_FIRST);
      send_item(ACT_REQUEST, 4, 30, FIT_FIRST);
      send_item(ACT_REQUEST, 255, 300, FIT_FIRST);
      send_item(ACT_RELEASE, 2, 0, FIT_FIRST);
      send_item(ACT_RELEASE, 4, 0, FIT_FIRST);
      send_item(ACT_REQUEST, 0, 20, FIT_FIRST);
      send_item(ACT_REQUEST, 10, 25, FIT_BEST);
      send_item(ACT_REQUEST, 11, 20, FIT_WORST);
      send_item(ACT_REQUEST, 12, 2097151, FIT_WORST);
      send_item(ACT_COMPACT, 0, 0, FIT_NONE);
   endtask

   task automatic test_table_full();
      set_total_size(64);
      for (int i = 0; i < NREG; i++) send_item(ACT_REQUEST, i, 1, FIT_FIRST);
      send_item(ACT_REQUEST, 99, 1, FIT_BEST);
      send_item(ACT_RELEASE, 3, 0, FIT_FIRST);
      send_item(ACT_RELEASE, 200, 0, FIT_FIRST);
      send_item(ACT_COMPACT, 0, 0, FIT_FIRST);
      set_total_size(0);
      send_item(ACT_REQUEST, 5, 1, FIT_WORST);
      set_total_size(40);
      send_item(ACT_REQUEST, 5, 1, FIT_FIRST);
      for (int i = 0; i < 70; i++) send_item(ACT_RELEASE, i, 0, FIT_FIRST);
   endtask

   task automatic test_random(longint unsigned total, int n);
      int pick;
      longint unsigned sz, top;
      set_total_size(total);
      top = (total & 64'h1FFFFF) / 40;
      if (top < 1) top = 1;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         sz = $urandom_range(1, int'(top > 1048576 ? 1048576 : top));
         if (pick < 58)
            send_item(ACT_REQUEST, $urandom_range(15), sz, $urandom_range(2));
         else if (pick < 83)
            send_item(ACT_RELEASE, $urandom_range(15), $urandom, $urandom_range(3));
         else if (pick < 88)
            send_item(ACT_COMPACT, $urandom_range(255), $urandom, $urandom_range(3));
         else
            send_item($urandom_range(3), $urandom_range(255), $urandom_range(2097151),
                      $urandom_range(3));
      end
   endtask

   initial begin
      space_total = TOTAL_RESET;
      tbl_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_random(1, 20);
      test_random(1000, 50);
      wait_drained();
      gaps_on = 1'b0;
      test_random(4096, 60);
      gaps_on = 1'b1;
      test_random(37, 50);
      test_random(2097151, 40);
      test_random(1048576, 40);
      test_random(300, 30);
      wait_drained();
      repeat (300) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

>>> sim.f
+incdir+design
design/cfa_pkg.sv
design/cfa_datapath.sv
design/cfa_control.sv
design/contiguous_fit_allocator.sv
dv/tb_contiguous_fit_allocator.sv
